// File: rtl/bpa_pkg.sv
// Package for the bitmap page allocator: field widths, request and register codes,
// and the request and result payload types.
// Depends on nothing; the interfaces, the word scan and the core use it.
package bpa_pkg;

    localparam int ADDR_W    = 48;
    localparam int CNT_W     = 17;
    localparam int REQ_W     = 2;
    localparam int RUN_W     = CNT_W + 1;

    localparam int NUM_PAGES_DEF  = 65536;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int WORD_BITS_DEF  = 32;

    localparam logic [REQ_W-1:0] REQ_ALLOC_ONE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC_RUN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE_ONE  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_FREE_RUN  = 2'd3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ADDR_W;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'd1;

    localparam logic [CNT_W-1:0] PAGES_IN_USE_RESET = 17'd65536;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ADDR_W-1:0] address;
        logic [CNT_W-1:0]  run_len;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] page_address;
        logic              ok;
        logic [CNT_W-1:0]  free_left;
    } t_rsp;

endpackage

// File: rtl/bpa_req_if.sv
// Request channel of the bitmap page allocator: valid, ready and a request payload.
// Depends on bpa_pkg for the payload type.
interface bpa_req_if;
    logic          valid;
    logic          ready;
    bpa_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/bpa_rsp_if.sv
// Result channel of the bitmap page allocator: valid, ready and a result payload.
// Depends on bpa_pkg for the payload type.
interface bpa_rsp_if;
    logic          valid;
    logic          ready;
    bpa_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/bpa_bitmap_ram.sv
// Single-port-write, single-port-read bitmap store with a registered read.
// Depends on nothing outside this file.
module bpa_bitmap_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32,
    parameter int AW    = 11
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bpa_word_scan.sv
// First-fit run evaluation over one bitmap word, carrying the run length in from
// the previous word. Depends on bpa_pkg for the count widths.
module bpa_word_scan #(
    parameter int WORD_BITS = 32,
    parameter int PW        = 5
) (
    input  logic [WORD_BITS-1:0]    i_free,
    input  logic [bpa_pkg::RUN_W-1:0] i_run,
    input  logic [bpa_pkg::CNT_W-1:0] i_need,
    output logic                    o_hit,
    output logic [PW-1:0]           o_pos,
    output logic [bpa_pkg::RUN_W-1:0] o_run_next
);
    import bpa_pkg::*;

    always_comb begin
        logic             all_free;
        logic [PW-1:0]    last_used;
        logic [RUN_W-1:0] run_i;
        o_hit     = 1'b0;
        o_pos     = '0;
        all_free  = 1'b1;
        last_used = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (!i_free[i]) begin
                all_free  = 1'b0;
                last_used = PW'(i);
            end
            run_i = all_free ? (i_run + RUN_W'(i + 1))
                             : (RUN_W'(i) - RUN_W'(last_used));
            if (i_free[i] && !o_hit && (run_i >= RUN_W'(i_need))) begin
                o_hit = 1'b1;
                o_pos = PW'(i);
            end
        end
        o_run_next = all_free ? (i_run + RUN_W'(WORD_BITS))
                              : (RUN_W'(WORD_BITS - 1) - RUN_W'(last_used));
    end

endmodule

// File: rtl/bitmap_page_allocator_core.sv
// Bitmap physical page allocator, first fit: one used bit per page held in a
// synchronous memory of WORD_BITS-wide words, plus a free-page count. After reset
// the block clears the bitmap word by word and takes no request during that pass;
// configuration writes are taken throughout. One request is handled at a time.
// An allocation first issues the read of word zero, then scans the bitmap words
// one after another until the run is found or the managed range ends, then sets
// the used bits word by word of the run, walking downwards from the word where the
// run ends; a refused allocation goes straight to the done state. For a free, each
// page in the managed range passes through a range check, word-index division by
// reciprocal multiply, memory read and write back, while a page outside it only
// passes the range check. The done state hands the result to the output register
// once that register is empty or being read; the register parts the two sides so
// that the next request is taken while the result still waits.
module bitmap_page_allocator_core #(
    parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF,
    parameter int WORD_BITS  = bpa_pkg::WORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bpa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bpa_req_if.sink                        i_req,
    bpa_rsp_if.source                      o_rsp
);
    import bpa_pkg::*;

    // Memory geometry and the widths of page arithmetic.
    localparam int NWORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int PW     = $clog2(WORD_BITS);
    localparam int PGW1   = $clog2(NUM_PAGES + WORD_BITS + 1);
    localparam int AW1    = ADDR_W + 1;
    // Reciprocal for page / WORD_BITS, exact for every page index below 2^PGW1.
    localparam int RS     = PGW1 + $clog2(WORD_BITS);
    localparam longint unsigned RECIP =
        ((64'd1 << RS) + longint'(WORD_BITS) - 64'd1) / longint'(WORD_BITS);

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SRCH0 = 4'd2;
    localparam logic [3:0] ST_SRCH  = 4'd3;
    localparam logic [3:0] ST_MARK  = 4'd4;
    localparam logic [3:0] ST_FCHK  = 4'd5;
    localparam logic [3:0] ST_FDIV  = 4'd6;
    localparam logic [3:0] ST_FRD   = 4'd7;
    localparam logic [3:0] ST_FWR   = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0]           r_state, n_state;
    logic [AW-1:0]        r_w, n_w;
    logic [PGW1-1:0]      r_wbase, n_wbase;
    logic [RUN_W-1:0]     r_run, n_run;
    logic [CNT_W-1:0]     r_need, n_need;
    logic [PW-1:0]        r_hi, n_hi;
    logic [CNT_W-1:0]     r_left, n_left;
    logic [AW1-1:0]       r_cur, n_cur;
    logic [AW1-1:0]       r_end, n_end;
    logic [PGW1-1:0]      r_pg, n_pg;
    logic [AW-1:0]        r_q, n_q;
    logic [PW-1:0]        r_bit, n_bit;
    logic [CNT_W-1:0]     r_free, n_free;
    logic [ADDR_W-1:0]    r_base;
    logic [CNT_W-1:0]     r_pages;
    logic [ADDR_W-1:0]    r_res, n_res;
    logic                 r_ok, n_ok;
    logic                 r_ov, n_ov;
    t_rsp                 r_out, n_out;

    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

    logic [WORD_BITS-1:0] scan_free;
    logic                 scan_hit;
    logic [PW-1:0]        scan_pos;
    logic [RUN_W-1:0]     scan_run_next;

    logic [CNT_W-1:0]     managed;
    logic [PGW1-1:0]      managed_pg;

    // Managed page count is the written page count capped at the bitmap size.
    function automatic logic [CNT_W-1:0] cap_pages(input logic [CNT_W-1:0] pages);
        cap_pages = (32'(pages) < 32'(NUM_PAGES)) ? pages : CNT_W'(NUM_PAGES);
    endfunction

    assign managed    = cap_pages(r_pages);
    assign managed_pg = PGW1'(managed);

    bpa_bitmap_ram #(
        .DEPTH (NWORDS),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Free bits of the word under search; pages at or past the managed count
    // count as used so that a run never reaches them.
    always_comb begin
        logic [PGW1-1:0] lim;
        lim = managed_pg - r_wbase;
        for (int i = 0; i < WORD_BITS; i++) begin
            scan_free[i] = !mem_rdata[i] && (PGW1'(i) < lim);
        end
    end

    bpa_word_scan #(
        .WORD_BITS (WORD_BITS),
        .PW        (PW)
    ) u_scan (
        .i_free     (scan_free),
        .i_run      (r_run),
        .i_need     (r_need),
        .o_hit      (scan_hit),
        .o_pos      (scan_pos),
        .o_run_next (scan_run_next)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_out;

    always_comb begin
        logic [CNT_W-1:0]     n_req;
        logic [PGW1-1:0]      end_pg;
        logic [PGW1-1:0]      start_pg;
        logic [CNT_W-1:0]     span;
        logic [PW-1:0]        lo;
        logic [CNT_W-1:0]     take;
        logic [WORD_BITS-1:0] mask;
        logic [AW1-1:0]       diff;
        logic [63:0]          prod;
        logic [PGW1-1:0]      q_mul;
        logic                 in_range;
        logic                 step_free;

        n_state   = r_state;
        n_w       = r_w;
        n_wbase   = r_wbase;
        n_run     = r_run;
        n_need    = r_need;
        n_hi      = r_hi;
        n_left    = r_left;
        n_cur     = r_cur;
        n_end     = r_end;
        n_pg      = r_pg;
        n_q       = r_q;
        n_bit     = r_bit;
        n_free    = r_free;
        n_res     = r_res;
        n_ok      = r_ok;
        n_out     = r_out;
        n_ov      = r_ov && !o_rsp.ready;
        mem_we    = 1'b0;
        mem_waddr = r_w;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_w;
        step_free = 1'b0;

        n_req     = (i_req.data.req_type == REQ_ALLOC_ONE) ? CNT_W'(1) : i_req.data.run_len;
        end_pg    = r_wbase + PGW1'(scan_pos);
        start_pg  = end_pg + PGW1'(1) - PGW1'(r_need);
        span      = CNT_W'(r_hi) + CNT_W'(1);
        if (r_left >= span) begin
            lo   = '0;
            take = span;
        end else begin
            lo   = PW'(span - r_left);
            take = r_left;
        end
        for (int i = 0; i < WORD_BITS; i++) begin
            mask[i] = (PW'(i) >= lo) && (PW'(i) <= r_hi);
        end
        in_range  = (r_cur >= AW1'(r_base)) && (r_cur < r_end);
        diff      = r_cur - AW1'(r_base);
        prod      = 64'(r_pg) * RECIP;
        q_mul     = PGW1'(r_q) * PGW1'(WORD_BITS);

        case (r_state)
            ST_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_w;
                mem_wdata = '0;
                n_w       = r_w + AW'(1);
                if (r_w == AW'(NWORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_res = '0;
                    n_ok  = 1'b0;
                    case (i_req.data.req_type)
                        REQ_ALLOC_ONE, REQ_ALLOC_RUN: begin
                            n_need  = n_req;
                            n_w     = '0;
                            n_wbase = '0;
                            n_run   = '0;
                            if (n_req == '0 || r_free == '0 || r_free < n_req) begin
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_SRCH0;
                            end
                        end
                        default: begin
                            n_ok   = 1'b1;
                            n_left = (i_req.data.req_type == REQ_FREE_ONE) ?
                                     CNT_W'(1) : i_req.data.run_len;
                            n_cur  = AW1'(i_req.data.address);
                            n_end  = AW1'(r_base) + (AW1'(managed) << PAGE_SHIFT);
                            if (n_left == '0) begin
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_FCHK;
                            end
                        end
                    endcase
                end
            end
            ST_SRCH0: begin
                mem_re    = 1'b1;
                mem_raddr = r_w;
                n_state   = ST_SRCH;
            end
            ST_SRCH: begin
                mem_re = 1'b1;
                if (scan_hit) begin
                    // The run ends in this word; set its bits from here downwards.
                    mem_raddr = r_w;
                    n_hi      = scan_pos;
                    n_left    = r_need;
                    n_res     = ADDR_W'(AW1'(r_base) + (AW1'(start_pg) << PAGE_SHIFT));
                    n_state   = ST_MARK;
                end else begin
                    mem_raddr = r_w + AW'(1);
                    n_w       = r_w + AW'(1);
                    n_wbase   = r_wbase + PGW1'(WORD_BITS);
                    n_run     = scan_run_next;
                    if (r_wbase + PGW1'(WORD_BITS) >= managed_pg) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_MARK: begin
                mem_we    = 1'b1;
                mem_waddr = r_w;
                mem_wdata = mem_rdata | mask;
                n_left    = r_left - take;
                if (r_left == take) begin
                    n_free  = r_free - r_need;
                    n_ok    = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_w - AW'(1);
                    n_w       = r_w - AW'(1);
                    n_hi      = PW'(WORD_BITS - 1);
                end
            end
            ST_FCHK: begin
                if (in_range) begin
                    n_pg    = diff[PAGE_SHIFT +: PGW1];
                    n_state = ST_FDIV;
                end else begin
                    step_free = 1'b1;
                end
            end
            ST_FDIV: begin
                n_q     = AW'(prod >> RS);
                n_state = ST_FRD;
            end
            ST_FRD: begin
                mem_re    = 1'b1;
                mem_raddr = r_q;
                n_bit     = PW'(r_pg - q_mul);
                n_state   = ST_FWR;
            end
            ST_FWR: begin
                // Pages that are already free are left alone and not counted.
                if (mem_rdata[r_bit]) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_q;
                    mem_wdata = mem_rdata & ~(WORD_BITS'(1) << r_bit);
                    if (r_free < managed) begin
                        n_free = r_free + CNT_W'(1);
                    end
                end
                step_free = 1'b1;
            end
            ST_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_out.page_address = r_res;
                    n_out.ok           = r_ok;
                    n_out.free_left    = r_free;
                    n_ov               = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (step_free) begin
            n_left = r_left - CNT_W'(1);
            n_cur  = r_cur + (AW1'(1) << PAGE_SHIFT);
            if (r_left == CNT_W'(1)) begin
                n_state = ST_DONE;
            end else begin
                n_state = ST_FCHK;
            end
        end

        // Page count write reloads free count; user keeps it to idle (unchecked).
        if (i_cfg_we && i_cfg_idx == CFG_PAGES_IN_USE) begin
            n_free = cap_pages(i_cfg_data[CNT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_w     <= '0;
            r_ov    <= 1'b0;
            r_base  <= '0;
            r_pages <= PAGES_IN_USE_RESET;
            r_free  <= cap_pages(PAGES_IN_USE_RESET);
        end else begin
            r_state <= n_state;
            r_w     <= n_w;
            r_ov    <= n_ov;
            r_free  <= n_free;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE_ADDRESS: r_base  <= i_cfg_data[ADDR_W-1:0];
                    CFG_PAGES_IN_USE: r_pages <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wbase <= n_wbase;
        r_run   <= n_run;
        r_need  <= n_need;
        r_hi    <= n_hi;
        r_left  <= n_left;
        r_cur   <= n_cur;
        r_end   <= n_end;
        r_pg    <= n_pg;
        r_q     <= n_q;
        r_bit   <= n_bit;
        r_res   <= n_res;
        r_ok    <= n_ok;
        r_out   <= n_out;
    end

endmodule
